// ----- design/gbai_pkg.sv -----
// Shared types and constants for the gyro block average integrator.
// No dependencies; imported by every module of the block.
package gbai_pkg;

   localparam int RATE_W          = 16;
   localparam int GAIN_W          = 24;
   localparam int DEADBAND_W      = 15;
   localparam int ANGLE_W         = 32;
   localparam int ACC_W           = 48;
   localparam int PROD_W          = RATE_W + GAIN_W + 1;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 24;
   localparam int NUM_AXES        = 3;

   localparam int MAX_BLOCK_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [GAIN_W-1:0]     GAIN_RESET     = 24'd7340;
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd22;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND = 2'd1;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
      logic                     block_end;
   } req_type;

   typedef struct packed {
      logic signed [RATE_W-1:0]  avg_x;
      logic signed [RATE_W-1:0]  avg_y;
      logic signed [RATE_W-1:0]  avg_z;
      logic signed [ANGLE_W-1:0] angle_x;
      logic signed [ANGLE_W-1:0] angle_y;
      logic signed [ANGLE_W-1:0] angle_z;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic avail;
   } queue_status_type;

endpackage

// ----- design/gyro_block_average_integrator.sv -----
// Top level of the gyro block average integrator: config registers, front
// end, block queue and back end. Depends on gbai_pkg, gbai_front,
// gbai_queue and gbai_back.
//
//   port group  dir  handshake            payload
//   req_*       in   req_valid/req_stall  gbai_pkg::req_type
//   rsp_*       out  rsp_valid/rsp_stall  gbai_pkg::rsp_type
//   csr_*       in   csr_valid/csr_ready  csr_index, csr_data
//
// A sample that does not close a block only updates the front-end sums and count.
// A closed block passes through the bit-per-cycle divider and the shared
// multiplier in the back end; the queue holds QUEUE_DEPTH closed blocks,
// and req_stall rises while it is full.
// The result register frees the back end while rsp_stall is high.
// Synchronous active-high reset clears sums, counts and angles, presets CSRs.
module gyro_block_average_integrator #(
   parameter int MAX_BLOCK   = gbai_pkg::MAX_BLOCK_DEFAULT,
   parameter int QUEUE_DEPTH = gbai_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gbai_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gbai_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gbai_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbai_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gbai_pkg::*;

   localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W   = RATE_W + $clog2(MAX_BLOCK) + 1;
   localparam int ENTRY_W = NUM_AXES * SUM_W + CNT_W;

   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [DEADBAND_W-1:0] deadband_ff, deadband_in;

   queue_status_type q_status;
   logic push, pop;
   logic [ENTRY_W-1:0] push_data, head_data;

   assign csr_ready = 1'b1;

   always_comb begin
      gain_in     = gain_ff;
      deadband_in = deadband_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:     gain_in     = csr_data[GAIN_W-1:0];
            CSR_DEADBAND: deadband_in = csr_data[DEADBAND_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_RESET;
         deadband_ff <= DEADBAND_RESET;
      end else begin
         gain_ff     <= gain_in;
         deadband_ff <= deadband_in;
      end
   end

   gbai_front #(
      .MAX_BLOCK (MAX_BLOCK),
      .SUM_W     (SUM_W),
      .CNT_W     (CNT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   gbai_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   gbai_back #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .gain      (gain_ff),
      .deadband  (deadband_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/gbai_queue.sv -----
// Small FIFO of finished block sums between front and back.
// Depends on gbai_pkg for the status struct.
module gbai_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = gbai_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output gbai_pkg::queue_status_type status
);
   import gbai_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.avail = (fill_ff != '0);

endmodule

// ----- design/gbai_front.sv -----
// Front end: accepts rate items, keeps per-axis sums and the sample count,
// and queues the sums at each block close. Depends on gbai_pkg.
module gbai_front #(
   parameter int MAX_BLOCK = gbai_pkg::MAX_BLOCK_DEFAULT,
   parameter int SUM_W     = 22,
   parameter int CNT_W     = 6
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  gbai_pkg::req_type                         req_data,
   input  gbai_pkg::queue_status_type                q_status,
   output logic                                      push,
   output logic [gbai_pkg::NUM_AXES*SUM_W+CNT_W-1:0] push_data
);
   import gbai_pkg::*;

   logic signed [SUM_W-1:0] sums_ff [NUM_AXES];
   logic signed [SUM_W-1:0] sums_in [NUM_AXES];
   logic signed [RATE_W-1:0] rate [NUM_AXES];
   logic [CNT_W-1:0] count_ff, count_in, count_next;
   logic accept, last;

   always_comb begin
      rate[0] = req_data.rate_x;
      rate[1] = req_data.rate_y;
      rate[2] = req_data.rate_z;
      accept     = req_valid && !q_status.full;
      count_next = count_ff + CNT_W'(1);
      last       = req_data.block_end || (count_next >= CNT_W'(MAX_BLOCK));
      for (int i = 0; i < NUM_AXES; i++) begin
         sums_in[i] = sums_ff[i];
         if (accept) begin
            sums_in[i] = last ? '0
                       : sums_ff[i] + {{(SUM_W-RATE_W){rate[i][RATE_W-1]}}, rate[i]};
         end
      end
      count_in = count_ff;
      if (accept) begin
         count_in = last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            sums_ff[i] <= sums_in[i];
         end
      end
   end

   // entry: {count, sum_z, sum_y, sum_x}
   always_comb begin
      push_data = {count_next,
                   sums_ff[2] + {{(SUM_W-RATE_W){rate[2][RATE_W-1]}}, rate[2]},
                   sums_ff[1] + {{(SUM_W-RATE_W){rate[1][RATE_W-1]}}, rate[1]},
                   sums_ff[0] + {{(SUM_W-RATE_W){rate[0][RATE_W-1]}}, rate[0]}};
   end

   assign push      = accept && last;
   assign req_stall = q_status.full;

endmodule

// ----- design/gbai_back.sv -----
// Back end: divides queued sums by the block count (one quotient bit per
// cycle, three axes side by side), applies the deadband, integrates through
// one shared multiplier and holds the result register. Depends on gbai_pkg.
module gbai_back #(
   parameter int SUM_W = 22,
   parameter int CNT_W = 6
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  gbai_pkg::queue_status_type                q_status,
   input  logic [gbai_pkg::NUM_AXES*SUM_W+CNT_W-1:0] head_data,
   output logic                                      pop,
   input  logic [gbai_pkg::GAIN_W-1:0]               gain,
   input  logic [gbai_pkg::DEADBAND_W-1:0]           deadband,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output gbai_pkg::rsp_type                         rsp_data
);
   import gbai_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FIX  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam int BIT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
   localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);

   logic [2:0] state_ff, state_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [1:0] axis_ff, axis_in;
   logic [CNT_W-1:0] div_ff, div_in;

   logic [SUM_W-1:0] mag_ff [NUM_AXES];
   logic [SUM_W-1:0] mag_in [NUM_AXES];
   logic [SUM_W-1:0] quo_ff [NUM_AXES];
   logic [SUM_W-1:0] quo_in [NUM_AXES];
   logic [CNT_W-1:0] rem_ff [NUM_AXES];
   logic [CNT_W-1:0] rem_in [NUM_AXES];
   logic             neg_ff [NUM_AXES];
   logic             neg_in [NUM_AXES];
   logic signed [RATE_W-1:0] avg_ff [NUM_AXES];
   logic signed [RATE_W-1:0] avg_in [NUM_AXES];
   logic             pass_ff [NUM_AXES];
   logic             pass_in [NUM_AXES];
   logic [ACC_W-1:0] acc_ff [NUM_AXES];
   logic [ACC_W-1:0] acc_in [NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [SUM_W-1:0] head_sum [NUM_AXES];
   logic [CNT_W:0] trial [NUM_AXES];
   logic rsp_valid_ff, rsp_valid_in, load;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         head_sum[i] = head_data[i*SUM_W +: SUM_W];
         trial[i]    = {rem_ff[i], mag_ff[i][SUM_W-1]};
      end

      state_in = state_ff;
      bit_in   = bit_ff;
      axis_in  = axis_ff;
      div_in   = div_ff;
      prod_in  = prod_ff;
      pop      = 1'b0;
      load     = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         mag_in[i]  = mag_ff[i];
         quo_in[i]  = quo_ff[i];
         rem_in[i]  = rem_ff[i];
         neg_in[i]  = neg_ff[i];
         avg_in[i]  = avg_ff[i];
         pass_in[i] = pass_ff[i];
         acc_in[i]  = acc_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.avail) begin
               pop    = 1'b1;
               div_in = head_data[NUM_AXES*SUM_W +: CNT_W];
               bit_in = '0;
               for (int i = 0; i < NUM_AXES; i++) begin
                  neg_in[i] = head_sum[i][SUM_W-1];
                  mag_in[i] = head_sum[i][SUM_W-1] ? SUM_W'(-head_sum[i])
                                                   : SUM_W'(head_sum[i]);
                  quo_in[i] = '0;
                  rem_in[i] = '0;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               mag_in[i] = {mag_ff[i][SUM_W-2:0], 1'b0};
               if (trial[i] >= {1'b0, div_ff}) begin
                  rem_in[i] = CNT_W'(trial[i] - {1'b0, div_ff});
                  quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = CNT_W'(trial[i]);
                  quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
               end
            end
            bit_in = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(SUM_W - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               avg_in[i]  = neg_ff[i] ? -RATE_W'(quo_ff[i]) : RATE_W'(quo_ff[i]);
               pass_in[i] = quo_ff[i] > {{(SUM_W-DEADBAND_W){1'b0}}, deadband};
            end
            axis_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = avg_ff[axis_ff] * $signed({1'b0, gain});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (pass_ff[axis_ff]) begin
               acc_in[axis_ff] = acc_ff[axis_ff]
                               + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            end
            axis_in = axis_ff + 2'd1;
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_in.avg_x   = avg_ff[0];
         rsp_in.avg_y   = avg_ff[1];
         rsp_in.avg_z   = avg_ff[2];
         rsp_in.angle_x = acc_ff[0][ACC_W-1 -: ANGLE_W];
         rsp_in.angle_y = acc_ff[1][ACC_W-1 -: ANGLE_W];
         rsp_in.angle_z = acc_ff[2][ACC_W-1 -: ANGLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      axis_ff <= axis_in;
      div_ff  <= div_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
      for (int i = 0; i < NUM_AXES; i++) begin
         mag_ff[i]  <= mag_in[i];
         quo_ff[i]  <= quo_in[i];
         rem_ff[i]  <= rem_in[i];
         neg_ff[i]  <= neg_in[i];
         avg_ff[i]  <= avg_in[i];
         pass_ff[i] <= pass_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- bench/gyro_block_average_integrator_test.sv -----
// Self-checking bench for gyro_block_average_integrator: random and directed rate
// samples against an in-bench block average, deadband and angle predictor.
// Depends on gbai_pkg and the gyro_block_average_integrator RTL.
module gyro_block_average_integrator_test;
   import gbai_pkg::*;

   localparam int BLOCK_LIMIT = MAX_BLOCK_DEFAULT;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 100;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   req_type pending_samples[$];
   rsp_type expected_results[$];
   logic req_accepted = 1'b0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int burst_requests = 0;
   int bursts_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   // predictor state
   int block_sum[NUM_AXES];
   int block_count;
   logic [ACC_W-1:0] angle_acc[NUM_AXES];
   logic [GAIN_W-1:0] gain_q24;
   logic [DEADBAND_W-1:0] deadband;

   gyro_block_average_integrator u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic bit accumulate_sample(input req_type s, output rsp_type r);
      int rate[NUM_AXES];
      int avg[NUM_AXES];
      int magnitude;
      longint step;
      rate[0] = int'($signed(s.rate_x));
      rate[1] = int'($signed(s.rate_y));
      rate[2] = int'($signed(s.rate_z));
      r = '0;
      for (int i = 0; i < NUM_AXES; i++) block_sum[i] += rate[i];
      block_count++;
      if (!s.block_end && block_count < BLOCK_LIMIT) return 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         avg[i] = block_sum[i] / block_count;
         magnitude = (avg[i] < 0) ? -avg[i] : avg[i];
         if (magnitude > int'(deadband)) begin
            step = longint'(avg[i]) * longint'(gain_q24);
            angle_acc[i] = angle_acc[i] + step[ACC_W-1:0];
         end
         block_sum[i] = 0;
      end
      block_count = 0;
      r.avg_x = 16'(avg[0]);
      r.avg_y = 16'(avg[1]);
      r.avg_z = 16'(avg[2]);
      r.angle_x = angle_acc[0][ACC_W-1:16];
      r.angle_y = angle_acc[1][ACC_W-1:16];
      r.angle_z = angle_acc[2][ACC_W-1:16];
      return 1'b1;
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result at %0t: avg %0d %0d %0d angle %0d %0d %0d", $time,
                     got.avg_x, got.avg_y, got.avg_z, got.angle_x, got.angle_y, got.angle_z);
      end else begin
         want = expected_results.pop_front();
         if (got.avg_x !== want.avg_x || got.avg_y !== want.avg_y ||
             got.avg_z !== want.avg_z || got.angle_x !== want.angle_x ||
             got.angle_y !== want.angle_y || got.angle_z !== want.angle_z) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch at %0t: expected avg %0d %0d %0d angle %0d %0d %0d", $time,
                        want.avg_x, want.avg_y, want.avg_z,
                        want.angle_x, want.angle_y, want.angle_z);
               $display("                 actual avg %0d %0d %0d angle %0d %0d %0d",
                        got.avg_x, got.avg_y, got.avg_z, got.angle_x, got.angle_y, got.angle_z);
            end
         end
      end
   endtask

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         req_valid <= 1'b1;
      end else if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
         req_data <= pending_samples.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (bursts_served != burst_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         bursts_served <= bursts_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type predicted;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            if (accumulate_sample(req_data, predicted)) expected_results.push_back(predicted);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("gyro_block_average_integrator_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_sample(input logic signed [RATE_W-1:0] x, input logic signed [RATE_W-1:0] y,
                               input logic signed [RATE_W-1:0] z, input logic last);
      req_type s;
      s.rate_x = x;
      s.rate_y = y;
      s.rate_z = z;
      s.block_end = last;
      pending_samples.push_back(s);
   endtask

   function automatic logic signed [RATE_W-1:0] near_deadband();
      int v;
      v = int'(deadband) + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if ($urandom_range(1) == 1) v = -v;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   function automatic logic signed [RATE_W-1:0] pick_rate();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return near_deadband();
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random_block();
      int len;
      int shape;
      bit steady;
      logic signed [RATE_W-1:0] sx, sy, sz;
      shape = $urandom_range(19);
      if (shape == 0) len = $urandom_range(BLOCK_LIMIT, BLOCK_LIMIT + 8);
      else if (shape == 1) len = BLOCK_LIMIT - 1;
      else len = $urandom_range(1, 8);
      steady = ($urandom_range(3) == 0);
      sx = near_deadband();
      sy = near_deadband();
      sz = pick_rate();
      for (int i = 0; i < len; i++) begin
         if (steady) queue_sample(sx, sy, sz, i == len - 1);
         else queue_sample(pick_rate(), pick_rate(), pick_rate(), i == len - 1);
      end
   endtask

   task automatic settle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      if (index == CSR_GAIN) gain_q24 = data[GAIN_W-1:0];
      else if (index == CSR_DEADBAND) deadband = data[DEADBAND_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      gain_q24 = GAIN_RESET;
      deadband = DEADBAND_RESET;
      block_count = 0;
      for (int i = 0; i < NUM_AXES; i++) begin
         block_sum[i] = 0;
         angle_acc[i] = '0;
      end
      sender_idle_pct = 26;
      receiver_idle_pct = 73;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values: extremes, deadband edge, truncation
      queue_sample(16'sh7FFF, 16'sh8000, 16'sd0, 1'b1);
      queue_sample(16'sh8000, 16'sh7FFF, -16'sd1, 1'b1);
      queue_sample(16'sd23, -16'sd23, 16'sd22, 1'b0);
      queue_sample(16'sd23, -16'sd23, 16'sd22, 1'b1);
      queue_sample(16'sd1, -16'sd1, 16'sd5, 1'b0);
      queue_sample(16'sd1, -16'sd1, 16'sd5, 1'b0);
      queue_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
      repeat (20) queue_random_block();
      settle();
      repeat (20) queue_random_block();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // top of range; upper data bits beyond the deadband width are dropped
      write_register(CSR_GAIN, 24'hFFFFFF);
      write_register(CSR_DEADBAND, 24'hFFFFFF);
      sender_idle_pct = 73;
      receiver_idle_pct = 26;
      // overlong block closes itself; x averages to -32768
      repeat (BLOCK_LIMIT) queue_sample(16'sh8000, 16'sh7FFF, 16'sd0, 1'b0);
      queue_sample(16'sh7FFF, -16'sh7FFF, 16'sh8000, 1'b1);
      repeat (15) queue_random_block();
      burst_requests = burst_requests + 1;
      repeat (60) queue_sample(pick_rate(), pick_rate(), pick_rate(), 1'b1);
      repeat (15) queue_random_block();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      write_register(CSR_SPARE_2, 24'($urandom));
      write_register(CSR_SPARE_3, 24'($urandom));
      write_register(CSR_GAIN, 24'd0);
      write_register(CSR_DEADBAND, 24'd0);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      repeat (35) queue_random_block();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      write_register(CSR_GAIN, 24'($urandom));
      write_register(CSR_DEADBAND, 24'($urandom_range(300)));
      repeat (15) queue_random_block();
      burst_requests = burst_requests + 1;
      repeat (60) queue_sample(pick_rate(), pick_rate(), pick_rate(), 1'b1);
      repeat (15) queue_random_block();
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("gyro_block_average_integrator_test OK");
      else
         $display("gyro_block_average_integrator_test NOT OK");
      $finish;
   end
endmodule

// ----- files.f -----
design/gbai_pkg.sv
design/gbai_queue.sv
design/gbai_front.sv
design/gbai_back.sv
design/gyro_block_average_integrator.sv
bench/gyro_block_average_integrator_test.sv
